// ----- design/qsc_pkg.sv -----
// Shared types and constants for the quaternion sign continuity block.
package qsc_pkg;

  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
  localparam logic [31:0] HALF_Q30   = 32'h2000_0000;
  localparam logic [31:0] MIN_LEN_RST = 32'd72058;

  typedef struct packed {
    logic            degen;
    logic [3:0]      neg;
    logic [3:0][30:0] v;
  } qsc_item_t;

endpackage

// ----- design/qsc_front.sv -----
// Front end: accept item, square, classify against threshold, scale magnitudes of normalized items.
module qsc_front import qsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic [31:0] in_w,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        push,
  output qsc_item_t   push_item,
  input  logic        full
);

  typedef enum logic [2:0] {F_IDLE, F_SQ, F_SUM, F_NORM, F_PUSH} fstate_t;

  fstate_t          state;
  logic [31:0]      min_length_sq;
  logic [3:0][31:0] mag;
  logic [3:0]       neg;
  logic [3:0][63:0] sq;
  logic [31:0]      maxm;
  logic             degen;

  logic [3:0][31:0] raw;
  logic [31:0]      max01;
  logic [31:0]      max23;
  logic [65:0]      len2;

  assign raw = {in_w, in_z, in_y, in_x};

  always_comb begin
    max01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    max23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
    len2  = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]) + 66'(sq[3]);
  end

  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !full;

  always_comb begin
    push_item.degen = degen;
    push_item.neg   = neg;
    for (int i = 0; i < 4; i++) begin
      push_item.v[i] = mag[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      min_length_sq <= MIN_LEN_RST;
    end else begin
      if (cfg_wr_en) begin
        min_length_sq <= cfg_wr_data;
      end
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < 4; i++) begin
              neg[i] <= raw[i][31];
              mag[i] <= raw[i][31] ? 32'(-raw[i]) : raw[i];
            end
            state <= F_SQ;
          end
        end
        F_SQ: begin
          for (int i = 0; i < 4; i++) begin
            sq[i] <= mag[i] * mag[i];
          end
          maxm  <= (max01 > max23) ? max01 : max23;
          state <= F_SUM;
        end
        F_SUM: begin
          if ((maxm == 32'd0) || (len2 < {34'd0, min_length_sq})) begin
            degen <= 1'b1;
            state <= F_PUSH;
          end else begin
            degen <= 1'b0;
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (maxm > ONE_Q30) begin
            for (int i = 0; i < 4; i++) begin
              mag[i] <= mag[i] >> 1;
            end
            state <= F_PUSH;
          end else if (maxm <= HALF_Q30) begin
            for (int i = 0; i < 4; i++) begin
              mag[i] <= mag[i] << 1;
            end
            maxm <= maxm << 1;
          end else begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- design/qsc_fifo.sv -----
// Short item queue between front end and back end.
module qsc_fifo import qsc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  qsc_item_t push_item,
  output logic      full,
  input  logic      pop,
  output qsc_item_t pop_item,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qsc_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/qsc_back.sv -----
// Back end: square root, per-lane division and continuity check for normalized items, output register.
module qsc_back import qsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  qsc_item_t   pop_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_w,
  output logic        degenerate,
  output logic        sign_flipped
);

  typedef enum logic [3:0] {
    B_IDLE, B_SQ, B_SUM, B_SQRT, B_DIVI, B_DIV, B_SIGN, B_PROD, B_DOT, B_OUT
  } bstate_t;

  bstate_t      state;
  logic [3:0]   neg;
  logic [30:0]  v    [4];
  logic [61:0]  sq   [4];
  logic [63:0]  rn;
  logic [63:0]  rr;
  logic [63:0]  rb;
  logic [31:0]  d;
  logic [31:0]  rem  [4];
  logic [31:0]  quo  [4];
  logic [4:0]   cnt;
  logic [31:0]  q    [4];
  logic signed [63:0] prod [4];
  logic [31:0]  prev [4];
  logic         prev_valid;
  logic         degen;
  logic         flip;
  logic [31:0]  out_q [4];

  logic [63:0]  sum_sq;
  logic [63:0]  r_plus_b;
  logic [31:0]  root;
  logic [60:0]  dvd  [4];
  logic [32:0]  trial [4];
  logic         ge   [4];
  logic [31:0]  sat  [4];
  logic signed [31:0] qs [4];
  logic signed [31:0] ps [4];
  logic signed [63:0] pr [4];
  logic signed [65:0] dot;
  logic         out_free;

  always_comb begin
    sum_sq   = 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]) + 64'(sq[3]);
    r_plus_b = rr + rb;
    root     = (rr[31:0] == 32'd0) ? 32'd1 : rr[31:0];
    dot      = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]) + 66'(prod[3]);
    for (int i = 0; i < 4; i++) begin
      dvd[i]   = {v[i], 30'd0} + 61'(root >> 1);
      trial[i] = {rem[i], quo[i][31]};
      ge[i]    = (trial[i] >= {1'b0, d});
      sat[i]   = (quo[i] > ONE_Q30) ? ONE_Q30 : quo[i];
      qs[i]    = q[i];
      ps[i]    = prev[i];
      pr[i]    = qs[i] * ps[i];
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == B_IDLE) && !empty;

  assign out_x = out_q[0];
  assign out_y = out_q[1];
  assign out_z = out_q[2];
  assign out_w = out_q[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      prev_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prev[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != B_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            neg   <= pop_item.neg;
            degen <= pop_item.degen;
            for (int i = 0; i < 4; i++) begin
              v[i] <= pop_item.v[i];
            end
            if (pop_item.degen) begin
              q[0] <= '0;
              q[1] <= '0;
              q[2] <= '0;
              q[3] <= ONE_Q30;
              flip  <= 1'b0;
              state <= B_OUT;
            end else begin
              state <= B_SQ;
            end
          end
        end
        B_SQ: begin
          for (int i = 0; i < 4; i++) begin
            sq[i] <= v[i] * v[i];
          end
          state <= B_SUM;
        end
        B_SUM: begin
          rn    <= sum_sq;
          rr    <= '0;
          rb    <= 64'h4000_0000_0000_0000;
          state <= B_SQRT;
        end
        B_SQRT: begin
          if (rn >= r_plus_b) begin
            rn <= rn - r_plus_b;
            rr <= (rr >> 1) + rb;
          end else begin
            rr <= rr >> 1;
          end
          rb <= rb >> 2;
          if (rb == 64'd1) begin
            state <= B_DIVI;
          end
        end
        B_DIVI: begin
          d     <= root;
          state <= B_DIV;
          cnt   <= '0;
        end
        B_DIV: begin
          for (int i = 0; i < 4; i++) begin
            rem[i] <= ge[i] ? 32'(trial[i] - {1'b0, d}) : trial[i][31:0];
            quo[i] <= {quo[i][30:0], ge[i]};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= B_SIGN;
          end
        end
        B_SIGN: begin
          for (int i = 0; i < 4; i++) begin
            q[i] <= neg[i] ? 32'(-sat[i]) : sat[i];
          end
          state <= B_PROD;
        end
        B_PROD: begin
          for (int i = 0; i < 4; i++) begin
            prod[i] <= pr[i];
          end
          state <= B_DOT;
        end
        B_DOT: begin
          flip <= prev_valid && dot[65];
          if (prev_valid && dot[65]) begin
            for (int i = 0; i < 4; i++) begin
              q[i] <= 32'(-q[i]);
            end
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            for (int i = 0; i < 4; i++) begin
              out_q[i] <= q[i];
            end
            degenerate   <= degen;
            sign_flipped <= flip;
            out_valid    <= 1'b1;
            if (!degen) begin
              for (int i = 0; i < 4; i++) begin
                prev[i] <= q[i];
              end
              prev_valid <= 1'b1;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (state == B_DIVI) begin
        for (int i = 0; i < 4; i++) begin
          rem[i] <= {3'd0, dvd[i][60:32]};
          quo[i] <= dvd[i][31:0];
        end
      end
    end
  end

endmodule

// ----- design/quaternion_sign_continuity.sv -----
// Top level of the quaternion sign continuity filter.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   input    | in_valid / in_stall   | in_x, in_y, in_z, in_w (Q3.28)
//   output   | out_valid / out_stall | out_x..out_w (Q1.30), degenerate, sign_flipped
//   config   | cfg_wr_en             | cfg_wr_data (min_length_sq)
//
// The front end squares and classifies each item and scales the magnitudes of a
// normalized item in up to 30 single-bit steps; in_stall holds until it is pushed.
// Back end: 32-step square root, then 32-step division in four lanes, for each
// normalized item, whose rate it sets; degenerate items go straight to the output.
// Synchronous reset clears the history and loads min_length_sq with 72058.
// The output register holds a result under out_stall while the back end moves on.
module quaternion_sign_continuity import qsc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic [31:0] in_w,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_w,
  output logic        degenerate,
  output logic        sign_flipped
);

  logic      push;
  qsc_item_t push_item;
  logic      full;
  logic      pop;
  qsc_item_t pop_item;
  logic      empty;

  qsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .in_w        (in_w),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_item   (push_item),
    .full        (full)
  );

  qsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  qsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_item     (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_w        (out_w),
    .degenerate   (degenerate),
    .sign_flipped (sign_flipped)
  );

endmodule
